>>> design/sorted_double_ended_priority_queue_macros.svh
// Assertion macros shared by the checker.
`ifndef SORTED_DOUBLE_ENDED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_DOUBLE_ENDED_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication.
`define SDEPQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SDEPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/sdepq_pkg.sv
package sdepq_pkg;

    localparam int WORD_W      = 32;
    localparam int TDATA_W     = 40;
    localparam int GROUP_CELLS = 32;

    typedef logic signed [WORD_W-1:0] word_t;

    localparam logic [1:0] MODE_INSERT  = 2'd0;
    localparam logic [1:0] MODE_REM_MIN = 2'd1;
    localparam logic [1:0] MODE_REM_MAX = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
    localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_REM_MIN,
        OP_REM_MAX
    } op_t;

    // Broadcast to every cell.
    typedef struct packed {
        logic  en;
        op_t   op;
        word_t value;
    } cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_MAX_SEL
    } state_t;

endpackage

>>> design/sdepq_cell.sv
module sdepq_cell
    import sdepq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cmd_t  cmd,
    input  word_t left_value,
    input  logic  left_valid,
    input  logic  left_place,
    input  word_t right_value,
    input  logic  right_valid,
    output word_t value,
    output logic  valid,
    output logic  place,
    output logic  last
);

    word_t value_reg;
    word_t value_next;
    logic  valid_reg;
    logic  valid_next;

    // At or beyond the insert point: empty, or holding a value >= the new one.
    assign place = !valid_reg || (value_reg >= cmd.value);
    assign last  = valid_reg && !right_valid;
    assign value = value_reg;
    assign valid = valid_reg;

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (cmd.en)
        begin
            case (cmd.op)
                OP_INSERT:
                begin
                    if (place)
                    begin
                        if (left_place)
                        begin
                            value_next = left_value;
                            valid_next = left_valid;
                        end
                        else
                        begin
                            value_next = cmd.value;
                            valid_next = 1'b1;
                        end
                    end
                end
                OP_REM_MIN:
                begin
                    value_next = right_value;
                    valid_next = right_valid;
                end
                OP_REM_MAX:
                begin
                    valid_next = valid_reg && right_valid;
                end
                default:
                begin
                    valid_next = valid_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

>>> design/sdepq_max_sel.sv
module sdepq_max_sel
    import sdepq_pkg::*;
#(
    parameter int CELLS = 7
)
(
    input  logic  clk,
    input  logic  load,
    input  logic  pick   [CELLS],
    input  word_t values [CELLS],
    output word_t result
);

    localparam int GROUPS = (CELLS + GROUP_CELLS - 1) / GROUP_CELLS;

    word_t grp_reg  [GROUPS];
    word_t grp_next [GROUPS];

    // First level: AND-OR of each group of cells; only one cell is picked.
    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            grp_next[g] = '0;
            for (int k = 0; k < GROUP_CELLS; k++)
            begin
                if (g * GROUP_CELLS + k < CELLS)
                begin
                    if (pick[g * GROUP_CELLS + k])
                    begin
                        grp_next[g] = grp_next[g] | values[g * GROUP_CELLS + k];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            grp_reg <= grp_next;
        end
    end

    // Second level: OR across the group registers.
    always_comb
    begin
        result = '0;
        for (int g = 0; g < GROUPS; g++)
        begin
            result = result | grp_reg[g];
        end
    end

endmodule

>>> design/sorted_double_ended_priority_queue.sv
// Channel | Dir | Bits | Contents
// s_*     | in  | 40   | request word: mode, value
// m_*     | out | 40   | result word: removed_value, status
//
// Insert, remove-smallest, unused mode and removal on an empty queue: result
// registered at the accept edge. Remove-largest on a non-empty queue: result passes
// the group register stage of the max selector, then the output register; s_tready
// is low in ST_MAX_SEL. Async active-low reset empties the queue (valid bits only).
// A stalled result holds the output register; the next word is taken in the
// cycle it drains. Capacity is RING_SLOTS-1 entries held in a row of sorted cells.
module sorted_double_ended_priority_queue
    import sdepq_pkg::*;
#(
    parameter int RING_SLOTS = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // [1:0] mode, [33:2] value, [39:34] zero
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata    // [31:0] removed_value, [33:32] status, [39:34] zero
);

    localparam int CELLS = RING_SLOTS - 1;

    logic [1:0] in_mode;
    word_t      in_value;
    logic       accept;
    logic       full;
    logic       empty;
    cmd_t       cmd;

    state_t state_reg;
    state_t state_next;
    logic   sel_load;
    logic   sel_done;

    logic       out_valid_reg;
    logic       out_valid_next;
    word_t      out_value_reg;
    word_t      out_value_next;
    logic [1:0] out_status_reg;
    logic [1:0] out_status_next;

    word_t cell_value [CELLS];
    logic  cell_valid [CELLS];
    logic  cell_place [CELLS];
    logic  cell_last  [CELLS];
    word_t max_value;

    assign in_mode  = s_tdata[1:0];
    assign in_value = s_tdata[WORD_W+1:2];
    assign accept   = s_tvalid && s_tready;

    // Entries are packed from cell 0 upward, smallest first.
    assign empty = !cell_valid[0];
    assign full  = cell_valid[CELLS-1];

    always_comb
    begin
        cmd.value = in_value;
        cmd.op    = OP_INSERT;
        cmd.en    = 1'b0;
        unique case (in_mode)
            MODE_INSERT:
            begin
                cmd.op = OP_INSERT;
                cmd.en = accept && !full;
            end
            MODE_REM_MIN:
            begin
                cmd.op = OP_REM_MIN;
                cmd.en = accept && !empty;
            end
            MODE_REM_MAX:
            begin
                cmd.op = OP_REM_MAX;
                cmd.en = accept && !empty;
            end
            default:
            begin
                cmd.en = 1'b0;
            end
        endcase
    end

    // Row of cells; each looks only at its two neighbours.
    for (genvar i = 0; i < CELLS; i++)
    begin : g_cell
        word_t lv;
        logic  lval;
        logic  lplace;
        word_t rv;
        logic  rval;

        if (i == 0)
        begin : g_first
            assign lv     = '0;
            assign lval   = 1'b0;
            assign lplace = 1'b0;
        end
        else
        begin : g_mid_l
            assign lv     = cell_value[i-1];
            assign lval   = cell_valid[i-1];
            assign lplace = cell_place[i-1];
        end

        if (i == CELLS - 1)
        begin : g_end
            assign rv   = '0;
            assign rval = 1'b0;
        end
        else
        begin : g_mid_r
            assign rv   = cell_value[i+1];
            assign rval = cell_valid[i+1];
        end

        sdepq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .left_value  (lv),
            .left_valid  (lval),
            .left_place  (lplace),
            .right_value (rv),
            .right_valid (rval),
            .value       (cell_value[i]),
            .valid       (cell_valid[i]),
            .place       (cell_place[i]),
            .last        (cell_last[i])
        );
    end

    // Largest entry is the last valid cell; picked out over two levels.
    sdepq_max_sel #(
        .CELLS (CELLS)
    ) u_max_sel (
        .clk    (clk),
        .load   (sel_load),
        .pick   (cell_last),
        .values (cell_value),
        .result (max_value)
    );

    // Control: remove-largest waits in ST_MAX_SEL for the selector's group register.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.en && cmd.op == OP_REM_MAX)
                begin
                    state_next = ST_MAX_SEL;
                end
            end
            ST_MAX_SEL:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        sel_load = 1'b0;
        sel_done = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = !out_valid_reg || m_tready;
                sel_load = cmd.en && cmd.op == OP_REM_MAX;
            end
            ST_MAX_SEL:
            begin
                sel_done = 1'b1;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Output register.
    always_comb
    begin
        out_valid_next  = out_valid_reg && !m_tready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        if (sel_done)
        begin
            out_valid_next  = 1'b1;
            out_value_next  = max_value;
            out_status_next = STATUS_OK;
        end
        else if (accept && !sel_load)
        begin
            out_valid_next  = 1'b1;
            out_value_next  = '0;
            out_status_next = STATUS_OK;
            unique case (in_mode)
                MODE_INSERT:
                begin
                    if (full)
                    begin
                        out_status_next = STATUS_OVERFLOW;
                    end
                end
                MODE_REM_MIN:
                begin
                    if (empty)
                    begin
                        out_status_next = STATUS_UNDERFLOW;
                    end
                    else
                    begin
                        out_value_next = cell_value[0];
                    end
                end
                MODE_REM_MAX:
                begin
                    out_status_next = STATUS_UNDERFLOW;
                end
                default:
                begin
                    out_status_next = STATUS_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(TDATA_W - WORD_W - 2){1'b0}}, out_status_reg, out_value_reg};

endmodule

>>> design/sdepq_checker.sv
`include "sorted_double_ended_priority_queue_macros.svh"

module sdepq_checker
    import sdepq_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic [TDATA_W-1:0] s_tdata,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata
);

    `SDEPQ_ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word changed while stalled")

    `SDEPQ_ASSERT_NOW(a_status, clk, rst_n, m_tvalid, m_tdata[33:32] <= STATUS_UNDERFLOW, "illegal status code")

    `SDEPQ_ASSERT_NOW(a_fault_zero, clk, rst_n, m_tvalid && m_tdata[33:32] != STATUS_OK, m_tdata[31:0] == 32'd0, "fault result carries a value")

    `SDEPQ_ASSERT_NEXT(a_quick, clk, rst_n, s_tvalid && s_tready && s_tdata[1:0] != MODE_REM_MAX, m_tvalid, "result missing one cycle after request")

endmodule

bind sorted_double_ended_priority_queue sdepq_checker u_sdepq_checker (.*);

>>> bench/tb_top.sv
module tb_top;
    import sdepq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_SLOTS  = 8;
    localparam int CAPACITY    = RING_SLOTS - 1;     // as many entries as the block has cells
    localparam int STALL_PCT   = 36;                 // idle cycles in a hundred
    localparam int RAND_ITEMS  = 700;
    localparam int WATCHDOG    = 4000;               // cycles with no word moving
    localparam int TAIL_CYCLES = 20;                 // settle time after last result

    // Mode code the block ignores; not in the package.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        word_t      removed;
        logic [1:0] status;
    } outcome_t;

    typedef struct {
        logic [1:0] mode;
        word_t      value;
        logic       pinned;      // expected outcome typed in below
        outcome_t   outcome;
    } vector_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;

    // Expectation travelling with the word on the slave side; sampled at accept.
    logic     pin_valid = 1'b0;
    outcome_t pin_outcome = '0;

    logic     steady = 1'b0;          // suppresses idling on both sides

    word_t    sorted_keys[$];         // predictor's copy of the queue contents
    outcome_t awaited_results[$];

    int       errors = 0;
    int       idle_cycles = 0;
    int       n_inserts = 0, n_overflows = 0, n_underflows = 0;
    int       n_rem_min = 0, n_rem_max = 0, n_unused = 0, n_results = 0;
    int       peak_fill = 0;

    sorted_double_ended_priority_queue #(
        .RING_SLOTS(RING_SLOTS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [1:0] mode, [33:2] value, [39:34] zero
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)     // [31:0] removed_value, [33:32] status, [39:34] zero
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Sorted-list view of the cell row: cell positions never show at the ports,
    // so only the ordered contents and the fill level matter.
    function automatic outcome_t predict_request(logic [1:0] mode, word_t value);
        outcome_t res;
        int       pos;
        res = '{removed: '0, status: STATUS_OK};
        case (mode)
            MODE_INSERT:
            begin
                n_inserts++;
                if (sorted_keys.size() >= CAPACITY)
                begin
                    res.status = STATUS_OVERFLOW;
                    n_overflows++;
                end
                else
                begin
                    // goes ahead of any equal entries; for values alone that is invisible
                    pos = sorted_keys.size();
                    for (int i = 0; i < sorted_keys.size(); i++)
                    begin
                        if (sorted_keys[i] >= value)
                        begin
                            pos = i;
                            break;
                        end
                    end
                    sorted_keys.insert(pos, value);
                    if (sorted_keys.size() > peak_fill)
                        peak_fill = sorted_keys.size();
                end
            end
            MODE_REM_MIN, MODE_REM_MAX:
            begin
                if (mode == MODE_REM_MIN)
                    n_rem_min++;
                else
                    n_rem_max++;
                if (sorted_keys.size() == 0)
                begin
                    res.status = STATUS_UNDERFLOW;
                    n_underflows++;
                end
                else if (mode == MODE_REM_MIN)
                    res.removed = sorted_keys.pop_front();
                else
                    res.removed = sorted_keys.pop_back();
            end
            default:
                n_unused++;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("[%0t] MISMATCH %s: got 0x%08h, want 0x%08h", $realtime, what, got, want);
    endtask

    // Monitor: checks the master side and predicts every accepted request.
    always @(posedge clk)
    begin : monitor
        outcome_t want;
        outcome_t got;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                n_results++;
                got.removed = m_tdata[31:0];
                got.status  = m_tdata[33:32];
                if (awaited_results.size() == 0)
                    report_mismatch("result word with nothing awaited", m_tdata[31:0], '0);
                else
                begin
                    want = awaited_results.pop_front();
                    if (got.removed !== want.removed)
                        report_mismatch("removed_value", got.removed, want.removed);
                    if (got.status !== want.status)
                        report_mismatch("status", 32'(got.status), 32'(want.status));
                end
            end
            if (s_tvalid && s_tready)
            begin
                want = predict_request(s_tdata[1:0], s_tdata[33:2]);
                if (pin_valid)
                    want = pin_outcome;
                awaited_results.push_back(want);
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    // Sink side back-pressure.
    always @(negedge clk)
    begin
        m_tready <= steady || ($urandom_range(0, 99) >= STALL_PCT);
    end

    // Watchdog: fires only when words stop moving.
    initial
    begin
        while (idle_cycles < WATCHDOG)
            @(posedge clk);
        $display("[%0t] watchdog: no word moved for %0d cycles", $realtime, WATCHDOG);
        $display("** sorted_double_ended_priority_queue: FAILED **");
        $finish;
    end

    // One request word; random gap in front unless idling is switched off.
    // Entered and left at a falling edge, so words can follow back to back.
    task automatic send_word(logic [1:0] mode, word_t value, logic pinned, outcome_t outcome);
        while (!steady && ($urandom_range(0, 99) < STALL_PCT))
        begin
            s_tvalid  <= 1'b0;
            pin_valid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid    <= 1'b1;
        s_tdata     <= {6'b0, value, mode};
        pin_valid   <= pinned;
        pin_outcome <= outcome;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    function automatic word_t pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return word_t'($signed($urandom_range(0, 16)) - 8);  // many ties
            4:          return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default:    return word_t'($urandom);
        endcase
    endfunction

    function automatic logic [1:0] pick_mode(int item);
        int ins_pct;
        int roll;
        // phases of filling, draining and balance so the fill level sweeps
        // from empty to full
        case ((item / 60) % 3)
            0:       ins_pct = 65;
            1:       ins_pct = 30;
            default: ins_pct = 50;
        endcase
        roll = $urandom_range(0, 99);
        if (roll < 3)
            return MODE_UNUSED;
        if ($urandom_range(0, 99) < ins_pct)
            return MODE_INSERT;
        return $urandom_range(0, 1) ? MODE_REM_MAX : MODE_REM_MIN;
    endfunction

    // Directed words. Typed outcomes only where obvious; the rest go through
    // the predictor.
    vector_t directed[] = '{
        '{MODE_REM_MIN, 32'sh0000_0000, 1'b1, '{32'sh0, STATUS_UNDERFLOW}},  // empty after reset
        '{MODE_REM_MAX, 32'sh7FFF_FFFF, 1'b1, '{32'sh0, STATUS_UNDERFLOW}},
        '{MODE_UNUSED,  32'shFFFF_FFFF, 1'b1, '{32'sh0, STATUS_OK}},         // ignored mode
        '{MODE_INSERT,  32'sh7FFF_FFFF, 1'b0, '{32'sh0, STATUS_OK}},
        '{MODE_INSERT,  32'sh8000_0000, 1'b0, '{32'sh0, STATUS_OK}},
        '{MODE_INSERT,  32'sh0000_0000, 1'b0, '{32'sh0, STATUS_OK}},
        '{MODE_INSERT,  32'shFFFF_FFFF, 1'b0, '{32'sh0, STATUS_OK}},
        '{MODE_INSERT,  32'sh0000_0000, 1'b0, '{32'sh0, STATUS_OK}},         // equal entry
        '{MODE_INSERT,  32'sh0000_0005, 1'b0, '{32'sh0, STATUS_OK}},
        '{MODE_INSERT,  32'sh0000_0005, 1'b0, '{32'sh0, STATUS_OK}},         // now full
        '{MODE_INSERT,  32'sh0000_0001, 1'b1, '{32'sh0, STATUS_OVERFLOW}},
        '{MODE_INSERT,  32'sh7FFF_FFFF, 1'b1, '{32'sh0, STATUS_OVERFLOW}},
        '{MODE_UNUSED,  32'sh5555_AAAA, 1'b1, '{32'sh0, STATUS_OK}},
        '{MODE_REM_MAX, 32'sh0000_0000, 1'b1, '{32'sh7FFF_FFFF, STATUS_OK}},
        '{MODE_REM_MIN, 32'sh0000_0000, 1'b1, '{32'sh8000_0000, STATUS_OK}},
        '{MODE_REM_MIN, 32'shAAAA_5555, 1'b0, '{32'sh0, STATUS_OK}},
        '{MODE_REM_MAX, 32'sh1234_5678, 1'b0, '{32'sh0, STATUS_OK}},
        '{MODE_REM_MIN, 32'sh0000_0000, 1'b0, '{32'sh0, STATUS_OK}},
        '{MODE_REM_MIN, 32'sh0000_0000, 1'b0, '{32'sh0, STATUS_OK}},
        '{MODE_REM_MAX, 32'sh0000_0000, 1'b0, '{32'sh0, STATUS_OK}},         // last entry
        '{MODE_REM_MAX, 32'sh0000_0000, 1'b1, '{32'sh0, STATUS_UNDERFLOW}},
        '{MODE_REM_MIN, 32'sh0000_0000, 1'b1, '{32'sh0, STATUS_UNDERFLOW}},
        '{MODE_INSERT,  32'shFFFF_FFF9, 1'b0, '{32'sh0, STATUS_OK}},
        '{MODE_REM_MAX, 32'sh0000_0000, 1'b0, '{32'sh0, STATUS_OK}}
    };

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[i])
            send_word(directed[i].mode, directed[i].value, directed[i].pinned,
                      directed[i].outcome);

        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            // one long stretch with both sides running flat out
            if (i == 150)
                steady = 1'b1;
            if (i == 300)
                steady = 1'b0;
            // hold off until the block has handed back every word in flight
            if (i == 350)
            begin
                s_tvalid  <= 1'b0;
                pin_valid <= 1'b0;
                while (awaited_results.size() != 0)
                    @(posedge clk);
                @(negedge clk);
            end
            send_word(pick_mode(i), pick_value(), 1'b0, '0);
        end
        s_tvalid  <= 1'b0;
        pin_valid <= 1'b0;

        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (awaited_results.size() != 0)
            report_mismatch("results never delivered", awaited_results.size(), 0);

        $display("Covered %0d inserts (%0d refused full), %0d remove-min, %0d remove-max,",
                 n_inserts, n_overflows, n_rem_min, n_rem_max);
        $display("%0d removals on empty, %0d ignored words; %0d results, peak fill %0d of %0d.",
                 n_underflows, n_unused, n_results, peak_fill, CAPACITY);
        if (errors == 0)
            $display("** sorted_double_ended_priority_queue: PASSED **");
        else
            $display("** sorted_double_ended_priority_queue: FAILED **");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/sdepq_pkg.sv
design/sdepq_cell.sv
design/sdepq_max_sel.sv
design/sorted_double_ended_priority_queue.sv
design/sdepq_checker.sv
bench/tb_top.sv
